### src/pscc_pkg.sv
// shared constants and types for the path segment collision check
`default_nettype none

package pscc_pkg;

    // field and register widths
    localparam int COORD_W = 32;
    localparam int CFG_W   = 32;

    // default fraction bits of the fixed-point coordinates
    localparam int FRAC_BITS_DEF = 16;

    // register reset values
    localparam logic [CFG_W-1:0]   SPEED_RESET    = 32'd98304;
    localparam logic [CFG_W-1:0]   TOL_RESET      = 32'd4295;
    localparam logic [2*CFG_W-1:0] SPEED_SQ_RESET = 64'd98304 * 64'd98304;

    // register indexes of the configuration port
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SPEED = 1'b0,
        CFG_COLL_TOL   = 1'b1
    } cfg_idx_t;

    // register stages of the orientation unit
    localparam int ORIENT_STAGES = 5;

endpackage

`default_nettype wire

### src/pscc_delay.sv
// shift line that keeps side data in step with the pipeline
`default_nettype none

module pscc_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [D];

    // first tap
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
        end
    end

    // remaining taps
    for (genvar k = 1; k < D; k++)
    begin : g_tap
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign dout = line_reg[D-1];

endmodule

`default_nettype wire

### src/pscc_sqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none

module pscc_sqrt #(
    parameter int SW = 66
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [SW-1:0]         in_sq,
    output logic                  out_valid,
    output logic [(SW+1)/2-1:0]   out_root
);

    localparam int RW = (SW + 1) / 2;
    localparam int TW = 2 * RW + 2;

    logic [TW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic          v_reg    [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        localparam int BI = RW - 1 - k;

        logic [TW-1:0] rem_src;
        logic [RW-1:0] root_src;
        logic          v_src;
        logic [TW-1:0] trial;
        logic          take;

        if (k == 0)
        begin : g_first
            assign rem_src  = TW'(in_sq);
            assign root_src = '0;
            assign v_src    = in_valid;
        end
        else
        begin : g_rest
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign v_src    = v_reg[k-1];
        end

        // (root + 2^i)^2 - root^2, lower root bits still zero
        assign trial = (TW'(root_src) << (BI + 1)) | (TW'(1) << (2 * BI));
        assign take  = rem_src >= trial;

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src;
            end
        end

        // remainder and partial root
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? rem_src - trial : rem_src;
                root_reg[k] <= take ? (root_src | (RW'(1) << BI)) : root_src;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_root  = root_reg[RW-1];

endmodule

`default_nettype wire

### src/pscc_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module pscc_div #(
    parameter int NW = 65,
    parameter int DW = 33,
    parameter int QW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          out_valid,
    output logic [QW-1:0] quot
);

    localparam int RMW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [RMW-1:0] rem_reg [QW];
    logic [DW-1:0]  den_reg [QW];
    logic [QW-1:0]  q_reg   [QW];
    logic           v_reg   [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int BI = QW - 1 - k;

        logic [RMW-1:0] rem_src;
        logic [DW-1:0]  den_src;
        logic [QW-1:0]  q_src;
        logic           v_src;
        logic [RMW-1:0] trial;
        logic           take;

        if (k == 0)
        begin : g_first
            assign rem_src = RMW'(num);
            assign den_src = den;
            assign q_src   = '0;
            assign v_src   = in_valid;
        end
        else
        begin : g_rest
            assign rem_src = rem_reg[k-1];
            assign den_src = den_reg[k-1];
            assign q_src   = q_reg[k-1];
            assign v_src   = v_reg[k-1];
        end

        assign trial = RMW'(den_src) << BI;
        assign take  = rem_src >= trial;

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src;
            end
        end

        // remainder, divisor and quotient bits
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? rem_src - trial : rem_src;
                den_reg[k] <= den_src;
                q_reg[k]   <= take ? (q_src | (QW'(1) << BI)) : q_src;
            end
        end
    end

    // a zero divisor means a zero step
    assign out_valid = v_reg[QW-1];
    assign quot      = (den_reg[QW-1] == '0) ? '0 : q_reg[QW-1];

endmodule

`default_nettype wire

### src/pscc_orient.sv
// orientation products, tolerance and box tests, final touch decision
`default_nettype none

module pscc_orient
    import pscc_pkg::*;
#(
    parameter int GW = 51
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [COORD_W-1:0] ax,
    input  logic signed [COORD_W-1:0] ay,
    input  logic signed [COORD_W-1:0] bx,
    input  logic signed [COORD_W-1:0] by,
    input  logic signed [COORD_W-1:0] cx,
    input  logic signed [COORD_W-1:0] cy,
    input  logic signed [GW-1:0]      ex,
    input  logic signed [GW-1:0]      ey,
    input  logic [CFG_W-1:0]          tol,
    output logic                      out_valid,
    output logic                      hit
);

    localparam int AW  = GW + 1;
    localparam int BW  = COORD_W + 1;
    localparam int ALO = AW / 2;
    localparam int AHI = AW - ALO;
    localparam int LOW = ALO + 1 + BW;
    localparam int HIW = AHI + BW;
    localparam int PRW = AW + BW;
    localparam int OW  = PRW + 1;

    typedef struct packed {
        logic c_on_ab;
        logic e_on_ab;
        logic a_on_ce;
        logic b_on_ce;
        logic overlap;
    } box_flags_t;

    // p lies between q1 and q2 in either order
    function automatic logic between(
        input logic signed [GW-1:0] p,
        input logic signed [GW-1:0] q1,
        input logic signed [GW-1:0] q2
    );
        return ((p >= q1) && (p <= q2)) || ((p >= q2) && (p <= q1));
    endfunction

    // the spans a1..a2 and b1..b2 share at least one point
    function automatic logic spans_meet(
        input logic signed [GW-1:0] a1,
        input logic signed [GW-1:0] a2,
        input logic signed [GW-1:0] b1,
        input logic signed [GW-1:0] b2
    );
        logic below;
        logic above;
        below = (a1 < b1) && (a1 < b2) && (a2 < b1) && (a2 < b2);
        above = (a1 > b1) && (a1 > b2) && (a2 > b1) && (a2 > b2);
        return !below && !above;
    endfunction

    logic signed [GW-1:0] axg;
    logic signed [GW-1:0] ayg;
    logic signed [GW-1:0] bxg;
    logic signed [GW-1:0] byg;
    logic signed [GW-1:0] cxg;
    logic signed [GW-1:0] cyg;

    logic signed [AW-1:0] opa_w   [8];
    logic signed [BW-1:0] opb_w   [8];
    logic signed [AW-1:0] opa_reg [8];
    logic signed [BW-1:0] opb_reg [8];
    logic signed [LOW-1:0] plo_w   [8];
    logic signed [HIW-1:0] phi_w   [8];
    logic signed [LOW-1:0] plo_reg [8];
    logic signed [HIW-1:0] phi_reg [8];
    logic signed [PRW-1:0] prod_w   [8];
    logic signed [PRW-1:0] prod_reg [8];
    logic signed [OW-1:0]  ori_w   [4];
    logic signed [OW-1:0]  ori_reg [4];

    box_flags_t box_w;
    box_flags_t box_reg [ORIENT_STAGES-1];
    logic       v_reg   [ORIENT_STAGES];
    logic       hit_reg;

    logic signed [OW-1:0] tol_pos;
    logic signed [OW-1:0] tol_neg;
    logic [3:0] near_w;
    logic [3:0] neg_w;
    logic [3:0] pos_w;
    logic       cross_w;
    logic       hit_w;

    // stage 1: coordinate differences and box tests
    assign axg = GW'(ax);
    assign ayg = GW'(ay);
    assign bxg = GW'(bx);
    assign byg = GW'(by);
    assign cxg = GW'(cx);
    assign cyg = GW'(cy);

    assign opa_w[0] = AW'(cxg) - AW'(axg);
    assign opb_w[0] = BW'(by) - BW'(ay);
    assign opa_w[1] = AW'(cyg) - AW'(ayg);
    assign opb_w[1] = BW'(bx) - BW'(ax);
    assign opa_w[2] = AW'(ex) - AW'(axg);
    assign opb_w[2] = BW'(by) - BW'(ay);
    assign opa_w[3] = AW'(ey) - AW'(ayg);
    assign opb_w[3] = BW'(bx) - BW'(ax);
    assign opa_w[4] = AW'(ey) - AW'(cyg);
    assign opb_w[4] = BW'(ax) - BW'(cx);
    assign opa_w[5] = AW'(ex) - AW'(cxg);
    assign opb_w[5] = BW'(ay) - BW'(cy);
    assign opa_w[6] = AW'(ey) - AW'(cyg);
    assign opb_w[6] = BW'(bx) - BW'(cx);
    assign opa_w[7] = AW'(ex) - AW'(cxg);
    assign opb_w[7] = BW'(by) - BW'(cy);

    assign box_w.c_on_ab = between(cxg, axg, bxg) && between(cyg, ayg, byg);
    assign box_w.e_on_ab = between(ex, axg, bxg) && between(ey, ayg, byg);
    assign box_w.a_on_ce = between(axg, cxg, ex) && between(ayg, cyg, ey);
    assign box_w.b_on_ce = between(bxg, cxg, ex) && between(byg, cyg, ey);
    assign box_w.overlap = spans_meet(axg, bxg, cxg, ex) && spans_meet(ayg, byg, cyg, ey);

    // stage 2: split partial products; stage 3: their sum
    for (genvar k = 0; k < 8; k++)
    begin : g_mul
        assign plo_w[k] = $signed({1'b0, opa_reg[k][ALO-1:0]}) * opb_reg[k];
        assign phi_w[k] = $signed(opa_reg[k][AW-1:ALO]) * opb_reg[k];
        assign prod_w[k] = (PRW'(phi_reg[k]) <<< ALO) + PRW'(plo_reg[k]);
    end

    // stage 4: orientations
    for (genvar k = 0; k < 4; k++)
    begin : g_ori
        assign ori_w[k] = OW'(prod_reg[2*k]) - OW'(prod_reg[2*k+1]);
        assign near_w[k] = (ori_reg[k] < tol_pos) && (ori_reg[k] > tol_neg);
        assign neg_w[k]  = ori_reg[k][OW-1];
        assign pos_w[k]  = !ori_reg[k][OW-1] && (ori_reg[k] != '0);
    end

    // stage 5: decision
    assign tol_pos = $signed({{(OW-CFG_W){1'b0}}, tol});
    assign tol_neg = -tol_pos;

    assign cross_w = ((neg_w[0] && pos_w[1]) || (pos_w[0] && neg_w[1])) &&
                     ((neg_w[2] && pos_w[3]) || (pos_w[2] && neg_w[3]));

    assign hit_w = cross_w ||
                   (near_w[0] && box_reg[ORIENT_STAGES-2].c_on_ab) ||
                   (near_w[1] && box_reg[ORIENT_STAGES-2].e_on_ab) ||
                   (near_w[2] && box_reg[ORIENT_STAGES-2].a_on_ce) ||
                   (near_w[3] && box_reg[ORIENT_STAGES-2].b_on_ce) ||
                   ((&near_w) && box_reg[ORIENT_STAGES-2].overlap);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORIENT_STAGES; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < ORIENT_STAGES; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 8; i++)
            begin
                opa_reg[i]  <= opa_w[i];
                opb_reg[i]  <= opb_w[i];
                plo_reg[i]  <= plo_w[i];
                phi_reg[i]  <= phi_w[i];
                prod_reg[i] <= prod_w[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                ori_reg[i] <= ori_w[i];
            end
            box_reg[0] <= box_w;
            for (int i = 1; i < ORIENT_STAGES - 1; i++)
            begin
                box_reg[i] <= box_reg[i-1];
            end
            hit_reg <= hit_w;
        end
    end

    assign out_valid = v_reg[ORIENT_STAGES-1];
    assign hit       = hit_reg;

endmodule

`default_nettype wire

### src/path_segment_collision_check_unit.sv
// path segment collision check: step build, root, divide, orientation test
// throughput: one request per cycle while in_stall is low; depth set by the 33-stage square root
//   pipeline followed by the 32-stage step divider
// reset clears all valid bits and loads step_speed 1.5 and tolerance 4295
// one result per request, kept in order through an output register and a skid stage
`default_nettype none

module path_segment_collision_check_unit
    import pscc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] drone_x,
    input  logic signed [COORD_W-1:0] drone_y,
    input  logic signed [COORD_W-1:0] target_x,
    input  logic signed [COORD_W-1:0] target_y,
    input  logic signed [COORD_W-1:0] ghost_x,
    input  logic signed [COORD_W-1:0] ghost_y,
    input  logic signed [COORD_W-1:0] ghost_dir_x,
    input  logic signed [COORD_W-1:0] ghost_dir_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      collide,
    output logic signed [COORD_W-1:0] next_x,
    output logic signed [COORD_W-1:0] next_y
);

    localparam int CW  = COORD_W;
    localparam int SPW = CFG_W;
    localparam int MW  = CW + 1;
    localparam int SQW = 2 * MW;
    localparam int NW  = MW + SPW;
    localparam int PW  = CW + SPW + 1;
    localparam int GW  = PW + 2 - FRAC_BITS;
    localparam int RW  = (SQW + 1) / 2;
    localparam int QW  = SPW;
    localparam int SIDE_W = 6 * CW + 2 * GW + 3;
    localparam logic signed [PW:0] HALF = (PW+1)'(1) << (FRAC_BITS - 1);

    // configuration registers
    logic [SPW-1:0]   step_speed_reg;
    logic [SPW-1:0]   tol_reg;
    logic [2*SPW-1:0] step_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_speed_reg <= SPEED_RESET;
            tol_reg        <= TOL_RESET;
            step_sq_reg    <= SPEED_SQ_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_STEP_SPEED: step_speed_reg <= cfg_data;
                    CFG_COLL_TOL:   tol_reg        <= cfg_data;
                endcase
            end
            step_sq_reg <= step_speed_reg * step_speed_reg;
        end
    end

    // pipeline advance, held only while the skid stage is full
    logic en;
    logic skid_v_reg;
    logic out_v_reg;

    assign en       = !skid_v_reg;
    assign in_stall = skid_v_reg;

    // stage a: differences, magnitudes, ghost products
    logic signed [MW-1:0] dx_w;
    logic signed [MW-1:0] dy_w;
    logic [MW-1:0]        adx_w;
    logic [MW-1:0]        ady_w;
    logic signed [PW-1:0] gpx_w;
    logic signed [PW-1:0] gpy_w;

    assign dx_w  = $signed({target_x[CW-1], target_x}) - $signed({drone_x[CW-1], drone_x});
    assign dy_w  = $signed({target_y[CW-1], target_y}) - $signed({drone_y[CW-1], drone_y});
    assign adx_w = dx_w[MW-1] ? MW'(-dx_w) : MW'(dx_w);
    assign ady_w = dy_w[MW-1] ? MW'(-dy_w) : MW'(dy_w);
    assign gpx_w = ghost_dir_x * $signed({1'b0, step_speed_reg});
    assign gpy_w = ghost_dir_y * $signed({1'b0, step_speed_reg});

    logic                 a_v_reg;
    logic signed [CW-1:0] a_ax_reg, a_ay_reg, a_tx_reg, a_ty_reg, a_cx_reg, a_cy_reg;
    logic [MW-1:0]        a_adx_reg, a_ady_reg;
    logic                 a_negx_reg, a_negy_reg;
    logic signed [PW-1:0] a_gpx_reg, a_gpy_reg;

    // stage b: squares, step numerators, ghost end
    logic [SQW-1:0]       sqx_w, sqy_w;
    logic [NW-1:0]        nx_w, ny_w;
    logic signed [PW:0]   rx_w, ry_w, sx_w, sy_w, ex_w, ey_w;

    assign sqx_w = a_adx_reg * a_adx_reg;
    assign sqy_w = a_ady_reg * a_ady_reg;
    assign nx_w  = a_adx_reg * step_speed_reg;
    assign ny_w  = a_ady_reg * step_speed_reg;
    assign rx_w  = $signed({a_gpx_reg[PW-1], a_gpx_reg}) + HALF;
    assign ry_w  = $signed({a_gpy_reg[PW-1], a_gpy_reg}) + HALF;
    assign sx_w  = rx_w >>> FRAC_BITS;
    assign sy_w  = ry_w >>> FRAC_BITS;
    assign ex_w  = sx_w + $signed({{(PW+1-CW){a_cx_reg[CW-1]}}, a_cx_reg});
    assign ey_w  = sy_w + $signed({{(PW+1-CW){a_cy_reg[CW-1]}}, a_cy_reg});

    logic                 b_v_reg;
    logic signed [CW-1:0] b_ax_reg, b_ay_reg, b_tx_reg, b_ty_reg, b_cx_reg, b_cy_reg;
    logic                 b_negx_reg, b_negy_reg;
    logic [SQW-1:0]       b_sqx_reg, b_sqy_reg;
    logic [NW-1:0]        b_nx_reg, b_ny_reg;
    logic signed [GW-1:0] b_ex_reg, b_ey_reg;

    // stage c: squared distance and snap test
    logic [SQW-1:0] s_w;
    logic           snap_w;

    assign s_w    = b_sqx_reg + b_sqy_reg;
    assign snap_w = s_w < SQW'(step_sq_reg);

    logic                 c_v_reg;
    logic signed [CW-1:0] c_ax_reg, c_ay_reg, c_tx_reg, c_ty_reg, c_cx_reg, c_cy_reg;
    logic                 c_negx_reg, c_negy_reg, c_snap_reg;
    logic [SQW-1:0]       c_s_reg;
    logic [NW-1:0]        c_nx_reg, c_ny_reg;
    logic signed [GW-1:0] c_ex_reg, c_ey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ax_reg   <= drone_x;
            a_ay_reg   <= drone_y;
            a_tx_reg   <= target_x;
            a_ty_reg   <= target_y;
            a_cx_reg   <= ghost_x;
            a_cy_reg   <= ghost_y;
            a_adx_reg  <= adx_w;
            a_ady_reg  <= ady_w;
            a_negx_reg <= dx_w[MW-1];
            a_negy_reg <= dy_w[MW-1];
            a_gpx_reg  <= gpx_w;
            a_gpy_reg  <= gpy_w;

            b_ax_reg   <= a_ax_reg;
            b_ay_reg   <= a_ay_reg;
            b_tx_reg   <= a_tx_reg;
            b_ty_reg   <= a_ty_reg;
            b_cx_reg   <= a_cx_reg;
            b_cy_reg   <= a_cy_reg;
            b_negx_reg <= a_negx_reg;
            b_negy_reg <= a_negy_reg;
            b_sqx_reg  <= sqx_w;
            b_sqy_reg  <= sqy_w;
            b_nx_reg   <= nx_w;
            b_ny_reg   <= ny_w;
            b_ex_reg   <= ex_w[GW-1:0];
            b_ey_reg   <= ey_w[GW-1:0];

            c_ax_reg   <= b_ax_reg;
            c_ay_reg   <= b_ay_reg;
            c_tx_reg   <= b_tx_reg;
            c_ty_reg   <= b_ty_reg;
            c_cx_reg   <= b_cx_reg;
            c_cy_reg   <= b_cy_reg;
            c_negx_reg <= b_negx_reg;
            c_negy_reg <= b_negy_reg;
            c_snap_reg <= snap_w;
            c_s_reg    <= s_w;
            c_nx_reg   <= b_nx_reg;
            c_ny_reg   <= b_ny_reg;
            c_ex_reg   <= b_ex_reg;
            c_ey_reg   <= b_ey_reg;
        end
    end

    // distance root
    logic          sq_v;
    logic [RW-1:0] sq_root;

    pscc_sqrt #(
        .SW (SQW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_v_reg),
        .in_sq     (c_s_reg),
        .out_valid (sq_v),
        .out_root  (sq_root)
    );

    // numerators wait for the root
    logic [2*NW-1:0] num_d;
    logic [NW-1:0]   dnx, dny;

    pscc_delay #(
        .W (2 * NW),
        .D (RW)
    ) u_num_dly (
        .clk  (clk),
        .en   (en),
        .din  ({c_nx_reg, c_ny_reg}),
        .dout (num_d)
    );

    assign {dnx, dny} = num_d;

    // step components
    logic          qx_v;
    logic [QW-1:0] qx, qy;

    pscc_div #(
        .NW (NW),
        .DW (RW),
        .QW (QW)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_v),
        .num       (dnx),
        .den       (sq_root),
        .out_valid (qx_v),
        .quot      (qx)
    );

    pscc_div #(
        .NW (NW),
        .DW (RW),
        .QW (QW)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_v),
        .num       (dny),
        .den       (sq_root),
        .out_valid (),
        .quot      (qy)
    );

    // points wait for root and divide
    logic [SIDE_W-1:0]    side_d;
    logic signed [CW-1:0] d_ax, d_ay, d_tx, d_ty, d_cx, d_cy;
    logic signed [GW-1:0] d_ex, d_ey;
    logic                 d_negx, d_negy, d_snap;

    pscc_delay #(
        .W (SIDE_W),
        .D (RW + QW)
    ) u_side_dly (
        .clk  (clk),
        .en   (en),
        .din  ({c_ax_reg, c_ay_reg, c_tx_reg, c_ty_reg, c_cx_reg, c_cy_reg,
                c_ex_reg, c_ey_reg, c_negx_reg, c_negy_reg, c_snap_reg}),
        .dout (side_d)
    );

    assign {d_ax, d_ay, d_tx, d_ty, d_cx, d_cy, d_ex, d_ey, d_negx, d_negy, d_snap} = side_d;

    // stage e: drone segment end, always between drone and target so it fits
    logic signed [MW-1:0] stx_w, sty_w, bxs_w, bys_w;
    logic signed [CW-1:0] bx_w, by_w;

    assign stx_w = d_negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign sty_w = d_negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    assign bxs_w = $signed({d_ax[CW-1], d_ax}) + stx_w;
    assign bys_w = $signed({d_ay[CW-1], d_ay}) + sty_w;
    assign bx_w  = d_snap ? d_tx : bxs_w[CW-1:0];
    assign by_w  = d_snap ? d_ty : bys_w[CW-1:0];

    logic                 e_v_reg;
    logic signed [CW-1:0] e_ax_reg, e_ay_reg, e_bx_reg, e_by_reg, e_cx_reg, e_cy_reg;
    logic signed [GW-1:0] e_ex_reg, e_ey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e_v_reg <= qx_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_ax_reg <= d_ax;
            e_ay_reg <= d_ay;
            e_bx_reg <= bx_w;
            e_by_reg <= by_w;
            e_cx_reg <= d_cx;
            e_cy_reg <= d_cy;
            e_ex_reg <= d_ex;
            e_ey_reg <= d_ey;
        end
    end

    // segment test
    logic or_v;
    logic or_hit;

    pscc_orient #(
        .GW (GW)
    ) u_orient (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_v_reg),
        .ax        (e_ax_reg),
        .ay        (e_ay_reg),
        .bx        (e_bx_reg),
        .by        (e_by_reg),
        .cx        (e_cx_reg),
        .cy        (e_cy_reg),
        .ex        (e_ex_reg),
        .ey        (e_ey_reg),
        .tol       (tol_reg),
        .out_valid (or_v),
        .hit       (or_hit)
    );

    // next point waits for the test
    logic [2*CW-1:0] nxt_d;

    pscc_delay #(
        .W (2 * CW),
        .D (ORIENT_STAGES)
    ) u_next_dly (
        .clk  (clk),
        .en   (en),
        .din  ({e_bx_reg, e_by_reg}),
        .dout (nxt_d)
    );

    // output register and skid stage control
    logic push, pop;
    logic out_v_next, skid_v_next;
    logic load_out, load_skid, out_from_skid;

    assign push = en && or_v;
    assign pop  = out_v_reg && !out_stall;

    always_comb
    begin
        out_v_next    = out_v_reg;
        skid_v_next   = skid_v_reg;
        load_out      = 1'b0;
        load_skid     = 1'b0;
        out_from_skid = 1'b0;
        priority if (skid_v_reg)
        begin
            if (pop)
            begin
                out_from_skid = 1'b1;
                skid_v_next   = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_v_reg || pop)
            begin
                load_out   = 1'b1;
                out_v_next = 1'b1;
            end
            else
            begin
                load_skid   = 1'b1;
                skid_v_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    // output and skid payload
    logic                 out_hit_reg, skid_hit_reg;
    logic signed [CW-1:0] out_x_reg, out_y_reg, skid_x_reg, skid_y_reg;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_hit_reg <= or_hit;
            out_x_reg   <= nxt_d[2*CW-1:CW];
            out_y_reg   <= nxt_d[CW-1:0];
        end
        else if (out_from_skid)
        begin
            out_hit_reg <= skid_hit_reg;
            out_x_reg   <= skid_x_reg;
            out_y_reg   <= skid_y_reg;
        end
        if (load_skid)
        begin
            skid_hit_reg <= or_hit;
            skid_x_reg   <= nxt_d[2*CW-1:CW];
            skid_y_reg   <= nxt_d[CW-1:0];
        end
    end

    assign out_valid = out_v_reg;
    assign collide   = out_hit_reg;
    assign next_x    = out_x_reg;
    assign next_y    = out_y_reg;

`ifndef SYNTHESIS
    a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid stage holds a request while output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && out_stall))
        else $error("skid stage filled while output was free");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg && !out_stall |=> out_v_reg && !skid_v_reg)
        else $error("skid stage did not drain into output register");
`endif

endmodule

`default_nettype wire

### bench/path_segment_collision_check_unit_tb.sv
// testbench for the path segment collision check unit
`timescale 1ns / 100ps

module path_segment_collision_check_unit_tb;
    import pscc_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int LATENCY = 74;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] ax, ay, tx, ty, gx, gy, gdx, gdy;
    } request_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] nx, ny;
    } segment_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    cfg_idx_t cfg_index = CFG_STEP_SPEED;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    request_t req = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic collide;
    logic signed [31:0] next_x, next_y;

    // model copy of the registers
    logic [31:0] speed_reg = SPEED_RESET;
    logic [31:0] tol_reg = TOL_RESET;

    segment_result_t expected_results[$];
    int errors = 0;
    longint cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    path_segment_collision_check_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .drone_x(req.ax), .drone_y(req.ay), .target_x(req.tx), .target_y(req.ty),
        .ghost_x(req.gx), .ghost_y(req.gy),
        .ghost_dir_x(req.gdx), .ghost_dir_y(req.gdy),
        .out_valid(out_valid), .out_stall(out_stall),
        .collide(collide), .next_x(next_x), .next_y(next_y)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // integer square root of a 128-bit value below 2^70, floor
    function automatic logic [63:0] root_floor(logic [127:0] s);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int i = 34; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= s)
                r = c;
        end
        return r;
    endfunction

    function automatic logic signed [127:0] orientation(
        logic signed [127:0] ax, ay, bx, by, cx, cy);
        return (cx - ax) * (by - ay) - (bx - ax) * (cy - ay);
    endfunction

    function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] ghost_end(logic signed [63:0] g,
                                                      logic signed [63:0] dir);
        logic signed [95:0] p;
        p = dir * $signed({64'd0, speed_reg}) + (96'sd1 <<< (FRAC - 1));
        return g + 64'(p >>> FRAC);
    endfunction

    function automatic logic signed [63:0] step_component(logic signed [63:0] d,
                                                           logic [63:0] root_dist);
        logic [127:0] mag;
        logic [127:0] q;
        if (root_dist == 0) return 0;
        mag = d < 0 ? 128'(-d) : 128'(d);
        q = (mag * 128'(speed_reg)) / 128'(root_dist);
        return d < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic bit low_mag(logic signed [127:0] o);
        logic [127:0] m;
        m = o < 0 ? -o : o;
        return m < 128'(tol_reg);
    endfunction

    function automatic bit in_bounds(logic signed [63:0] px, py, x1, y1, x2, y2);
        return px >= (x1 < x2 ? x1 : x2) && px <= (x1 > x2 ? x1 : x2)
            && py >= (y1 < y2 ? y1 : y2) && py <= (y1 > y2 ? y1 : y2);
    endfunction

    function automatic bit ranges_overlap(logic signed [63:0] a1, a2, b1, b2);
        return (a1 > a2 ? a1 : a2) >= (b1 < b2 ? b1 : b2)
            && (a1 < a2 ? a1 : a2) <= (b1 > b2 ? b1 : b2);
    endfunction

    // predicted drone step end and collision flag
    function automatic segment_result_t predict_segment(request_t r);
        logic signed [63:0] ax, ay, tx, ty, cx, cy, dx, dy, bx, by, ex, ey;
        logic [127:0] s;
        logic [63:0] root_dist;
        logic signed [127:0] o1, o2, o3, o4;
        bit z1, z2, z3, z4, hit;
        segment_result_t res;
        ax = r.ax; ay = r.ay; tx = r.tx; ty = r.ty; cx = r.gx; cy = r.gy;
        dx = tx - ax;
        dy = ty - ay;
        s = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        if (s < 128'(speed_reg) * 128'(speed_reg))
        begin
            bx = tx;
            by = ty;
        end
        else
        begin
            root_dist = root_floor(s);
            bx = ax + step_component(dx, root_dist);
            by = ay + step_component(dy, root_dist);
        end
        ex = ghost_end(cx, 64'(r.gdx));
        ey = ghost_end(cy, 64'(r.gdy));
        o1 = orientation(ax, ay, bx, by, cx, cy);
        o2 = orientation(ax, ay, bx, by, ex, ey);
        o3 = orientation(cx, cy, ex, ey, ax, ay);
        o4 = orientation(cx, cy, ex, ey, bx, by);
        z1 = low_mag(o1); z2 = low_mag(o2); z3 = low_mag(o3); z4 = low_mag(o4);
        hit = ((o1 > 0 && o2 < 0) || (o1 < 0 && o2 > 0))
            && ((o3 > 0 && o4 < 0) || (o3 < 0 && o4 > 0));
        hit |= z1 && in_bounds(cx, cy, ax, ay, bx, by);
        hit |= z2 && in_bounds(ex, ey, ax, ay, bx, by);
        hit |= z3 && in_bounds(ax, ay, cx, cy, ex, ey);
        hit |= z4 && in_bounds(bx, by, cx, cy, ex, ey);
        hit |= z1 && z2 && z3 && z4 && ranges_overlap(ax, bx, cx, ex)
            && ranges_overlap(ay, by, cy, ey);
        res.hit = hit;
        res.nx = 32'(clamp32(bx));
        res.ny = 32'(clamp32(by));
        return res;
    endfunction

    // receiver stall pattern
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // result checker
    always @(posedge clk)
    begin
        segment_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result: collide %0b next %0d,%0d",
                         $time, collide, next_x, next_y);
                errors++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (collide !== exp_res.hit)
                begin
                    $display("%0t collide expected %0b actual %0b",
                             $time, exp_res.hit, collide);
                    errors++;
                end
                if (next_x !== exp_res.nx)
                begin
                    $display("%0t next_x expected %0d actual %0d",
                             $time, exp_res.nx, next_x);
                    errors++;
                end
                if (next_y !== exp_res.ny)
                begin
                    $display("%0t next_y expected %0d actual %0d",
                             $time, exp_res.ny, next_y);
                    errors++;
                end
            end
        end
    end

    // one request, held until accepted; random idle ahead of it
    task automatic send_request(request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req <= r;
        expected_results.push_back(predict_segment(r));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_STEP_SPEED) speed_reg = val;
        else tol_reg = val;
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(20, 0)) - 10 <<< FRAC;
            2: return $signed($urandom_range(2000)) - 1000;
            default: return $signed($urandom_range(800000)) - 400000;
        endcase
    endfunction

    // random request: mostly near drone and ghost pairs, some full-range noise
    function automatic request_t random_request();
        request_t r;
        int m;
        m = $urandom_range(9) == 0 ? 0 : $urandom_range(3, 1);
        r.ax = rand_coord(m); r.ay = rand_coord(m);
        r.tx = r.ax + rand_coord(m); r.ty = r.ay + rand_coord(m);
        r.gx = r.ax + rand_coord(m); r.gy = r.ay + rand_coord(m);
        r.gdx = rand_coord(m); r.gdy = rand_coord(m);
        case ($urandom_range(5))
            // ghost aimed across the drone path
            0:
            begin
                r.gx = r.ax + (r.tx - r.ax) / 2 - r.gdx / 2;
                r.gy = r.ay + (r.ty - r.ay) / 2 - r.gdy / 2;
            end
            // ghost on the drone line
            1:
            begin
                r.gx = r.ax; r.gy = r.ay;
                r.gdx = r.tx - r.ax; r.gdy = r.ty - r.ay;
            end
            // target very close
            2:
            begin
                r.tx = r.ax + $signed($urandom_range(8)) - 4;
                r.ty = r.ay + $signed($urandom_range(8)) - 4;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_request(random_request());
    endtask

    // extremes, degenerate and collinear cases at reset settings
    task automatic test_directed;
        logic [31:0] mx, mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        send_request('{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        send_request('{mn, mn, mx, mx, mx, mn, mn, mx});
        send_request('{mx, mx, mn, mn, mn, mx, mx, mn});
        send_request('{mx, mn, mx, mn, mx, mn, mx, mn});
        send_request('{mn, mx, mx, mn, mn, mn, mx, mx});
        // proper crossing
        send_request('{32'd0, 32'd0, 32'h0010_0000, 32'd0,
                       32'h0000_8000, -32'sh0001_0000, 32'd0, 32'h0002_0000});
        // snap to a nearby target
        send_request('{32'h10000, 32'h10000, 32'h10100, 32'h10000,
                       32'h10080, 32'h10000, 32'd0, 32'd0});
        // collinear overlap
        send_request('{32'd0, 32'd0, 32'h0010_0000, 32'd0,
                       32'h0000_8000, 32'd0, 32'h0001_0000, 32'd0});
        // collinear disjoint
        send_request('{32'd0, 32'd0, 32'h0010_0000, 32'd0,
                       32'h0005_0000, 32'd0, 32'h0001_0000, 32'd0});
        // ghost end touches the drone start
        send_request('{32'd0, 32'd0, 32'h0010_0000, 32'd0,
                       32'd0, 32'h0001_8000, 32'd0, -32'sh0001_0000});
        // parallel offset
        send_request('{32'd0, 32'd0, 32'h0010_0000, 32'd0,
                       32'd0, 32'd1, 32'h0001_0000, 32'd0});
        // rounding of a negative half in the ghost end
        send_request('{32'd5, 32'd5, -32'sd7, 32'd3, 32'd1, -32'sd1, -32'sd1, 32'd1});
        send_request('{32'd1, 32'd2, 32'd3, 32'd4, 32'hffff, 32'h1, 32'hffff_ffff, 32'h8000});
        drain();
    endtask

    // several register settings including the extremes
    task automatic test_settings;
        write_reg(CFG_STEP_SPEED, 32'd0);
        write_reg(CFG_COLL_TOL, 32'd0);
        run_random(30);
        drain();
        write_reg(CFG_STEP_SPEED, 32'hffff_ffff);
        write_reg(CFG_COLL_TOL, 32'hffff_ffff);
        run_random(30);
        drain();
        write_reg(CFG_STEP_SPEED, 32'd1);
        write_reg(CFG_COLL_TOL, 32'd1);
        run_random(30);
        drain();
        write_reg(CFG_STEP_SPEED, 32'h0004_0000);
        write_reg(CFG_COLL_TOL, 32'd100000);
        run_random(30);
        drain();
        write_reg(CFG_STEP_SPEED, SPEED_RESET);
        write_reg(CFG_COLL_TOL, TOL_RESET);
    endtask

    // random traffic through phases of sender idling and receiver stalls
    task automatic test_flow_control;
        int idle_pct[4] = '{0, 47, 0, 6};
        int stall_pct[4] = '{0, 0, 47, 6};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            write_reg(CFG_STEP_SPEED, $urandom_range(32'h0008_0000));
            write_reg(CFG_COLL_TOL, $urandom_range(20000));
            run_random(110);
            // sender holds off until the pipe is empty
            in_valid <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge clk);
            run_random(110);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_settings();
        test_flow_control();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
